// File: design/spi_pkg.sv
package spi_pkg;

	// field and datapath widths
	localparam int CW = 16;             // coordinate bits
	localparam int DW = CW + 1;         // difference bits
	localparam int PW = 2 * DW + 1;     // cross product bits, signed
	localparam int MW = PW - 1;         // magnitude of denominator
	localparam int TF = 24;             // parameter fraction bits
	localparam int PF = 16;             // point fraction bits
	localparam int QP = DW + PF;        // quotient bits of every divider lane
	localparam int OW = CW + PF;        // point output bits
	localparam int NL = 4;              // divider lanes
	localparam int AW = MW + QP;        // divider accumulator bits
	localparam int MRG_W = 8;

	localparam logic [MRG_W-1:0] MARGIN_RST = MRG_W'(17);

	// divider lane order
	localparam int LANE_T = 0;
	localparam int LANE_U = 1;
	localparam int LANE_X = 2;
	localparam int LANE_Y = 3;

	typedef struct packed {
		logic signed [CW-1:0] seg1_start_x;
		logic signed [CW-1:0] seg1_start_y;
		logic signed [CW-1:0] seg1_end_x;
		logic signed [CW-1:0] seg1_end_y;
		logic signed [CW-1:0] seg2_start_x;
		logic signed [CW-1:0] seg2_start_y;
		logic signed [CW-1:0] seg2_end_x;
		logic signed [CW-1:0] seg2_end_y;
	} seg_item_t;

	typedef struct packed {
		logic                 crossing;
		logic [TF:0]          frac_on_first;
		logic [TF:0]          frac_on_second;
		logic signed [OW-1:0] cross_x;
		logic signed [OW-1:0] cross_y;
	} res_item_t;

	// data that rides beside the divider
	typedef struct packed {
		logic                 ok;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [CW-1:0] base_x;
		logic signed [CW-1:0] base_y;
	} side_t;

	typedef logic [NL-1:0][AW-1:0] acc_vec_t;

endpackage

// File: design/spi_front.sv
module spi_front
	import spi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  seg_item_t in_item,
	output logic      out_valid,
	output logic [MW-1:0] dvsr,
	output acc_vec_t  acc,
	output side_t     side
);

	// stage 1: edge vectors
	logic                 vld_s1;
	logic signed [DW-1:0] abx_s1, aby_s1, cdx_s1, cdy_s1, acx_s1, acy_s1;
	logic signed [CW-1:0] ax_s1, ay_s1;

	// stage 2: products
	logic                   vld_s2;
	logic signed [2*DW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [DW-1:0]   abx_s2, aby_s2;
	logic signed [CW-1:0]   ax_s2, ay_s2;

	// stage 3: denominator and numerators
	logic                 vld_s3;
	logic signed [PW-1:0] den_s3, tn_s3, un_s3;
	logic signed [DW-1:0] abx_s3, aby_s3;
	logic signed [CW-1:0] ax_s3, ay_s3;

	// stage 4: sign normalized
	logic                 vld_s4, ok_s4, negx_s4, negy_s4;
	logic [MW-1:0]        den_s4, tn_s4, un_s4;
	logic [DW-1:0]        magx_s4, magy_s4;
	logic signed [CW-1:0] ax_s4, ay_s4;

	// stage 5: point numerators
	logic                 vld_s5, ok_s5, negx_s5, negy_s5;
	logic [MW-1:0]        den_s5, tn_s5, un_s5;
	logic [DW+MW-1:0]     px_s5, py_s5;
	logic signed [CW-1:0] ax_s5, ay_s5;

	logic signed [PW-1:0] den_n, tn_n, un_n;
	logic signed [PW-1:0] den_u;
	logic                 neg;

	always_comb begin
		neg   = den_s3[PW-1];
		den_n = neg ? -den_s3 : den_s3;
		tn_n  = neg ? -tn_s3 : tn_s3;
		un_n  = neg ? -un_s3 : un_s3;
		den_u = den_n;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			abx_s1 <= DW'(in_item.seg1_end_x) - DW'(in_item.seg1_start_x);
			aby_s1 <= DW'(in_item.seg1_end_y) - DW'(in_item.seg1_start_y);
			cdx_s1 <= DW'(in_item.seg2_end_x) - DW'(in_item.seg2_start_x);
			cdy_s1 <= DW'(in_item.seg2_end_y) - DW'(in_item.seg2_start_y);
			acx_s1 <= DW'(in_item.seg2_start_x) - DW'(in_item.seg1_start_x);
			acy_s1 <= DW'(in_item.seg2_start_y) - DW'(in_item.seg1_start_y);
			ax_s1  <= in_item.seg1_start_x;
			ay_s1  <= in_item.seg1_start_y;

			m0_s2  <= abx_s1 * cdy_s1;
			m1_s2  <= aby_s1 * cdx_s1;
			m2_s2  <= acx_s1 * cdy_s1;
			m3_s2  <= acy_s1 * cdx_s1;
			m4_s2  <= acx_s1 * aby_s1;
			m5_s2  <= acy_s1 * abx_s1;
			abx_s2 <= abx_s1;
			aby_s2 <= aby_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;

			den_s3 <= PW'(m0_s2) - PW'(m1_s2);
			tn_s3  <= PW'(m2_s2) - PW'(m3_s2);
			un_s3  <= PW'(m4_s2) - PW'(m5_s2);
			abx_s3 <= abx_s2;
			aby_s3 <= aby_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;

			ok_s4   <= (den_s3 != '0) && (tn_n > 0) && (tn_n < den_u)
				&& (un_n > 0) && (un_n < den_u);
			den_s4  <= den_n[MW-1:0];
			tn_s4   <= tn_n[MW-1:0];
			un_s4   <= un_n[MW-1:0];
			negx_s4 <= abx_s3[DW-1];
			negy_s4 <= aby_s3[DW-1];
			magx_s4 <= abx_s3[DW-1] ? DW'(-abx_s3) : DW'(abx_s3);
			magy_s4 <= aby_s3[DW-1] ? DW'(-aby_s3) : DW'(aby_s3);
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;

			ok_s5   <= ok_s4;
			den_s5  <= den_s4;
			tn_s5   <= tn_s4;
			un_s5   <= un_s4;
			px_s5   <= magx_s4 * tn_s4;
			py_s5   <= magy_s4 * tn_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
		end
	end

	// divider lane setup: remainder in the high part, dividend bits below
	always_comb begin
		acc            = '0;
		acc[LANE_T]    = {tn_s5, QP'(0)};
		acc[LANE_U]    = {un_s5, QP'(0)};
		acc[LANE_X]    = {px_s5[DW+MW-1:DW], px_s5[DW-1:0], PF'(0)};
		acc[LANE_Y]    = {py_s5[DW+MW-1:DW], py_s5[DW-1:0], PF'(0)};
		side.ok        = ok_s5;
		side.neg_x     = negx_s5;
		side.neg_y     = negy_s5;
		side.base_x    = ax_s5;
		side.base_y    = ay_s5;
	end

	assign out_valid = vld_s5;
	assign dvsr      = den_s5;

endmodule

// File: design/spi_divpipe.sv
module spi_divpipe
	import spi_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [MW-1:0] dvsr,
	input  acc_vec_t      acc_in,
	input  side_t         side_in,
	output logic          out_valid,
	output acc_vec_t      acc_out,
	output side_t         side_out
);

	// one restoring step: shift, compare, conditional subtract
	function automatic logic [AW-1:0] div_step(input logic [AW-1:0] a,
		input logic [MW-1:0] d);
		logic [MW:0]   t;
		logic [MW+1:0] diff;
		logic          ge;
		t    = a[AW-1:QP-1];
		diff = {1'b0, t} - {2'b00, d};
		ge   = !diff[MW+1];
		return {(ge ? diff[MW-1:0] : t[MW-1:0]), a[QP-2:0], ge};
	endfunction

	logic [QP-1:0] vld_sn;
	logic [MW-1:0] dvsr_sn [QP];
	acc_vec_t      acc_sn  [QP];
	side_t         side_sn [QP];

	// one quotient bit per stage on every lane
	for (genvar k = 0; k < QP; k++) begin : g_stage
		logic          vld_in;
		logic [MW-1:0] dvsr_in;
		acc_vec_t      acc_prev;
		side_t         side_prev;
		acc_vec_t      nxt;

		// stage input: module ports or the previous stage
		if (k == 0) begin : g_head
			assign vld_in    = in_valid;
			assign dvsr_in   = dvsr;
			assign acc_prev  = acc_in;
			assign side_prev = side_in;
		end else begin : g_link
			assign vld_in    = vld_sn[k-1];
			assign dvsr_in   = dvsr_sn[k-1];
			assign acc_prev  = acc_sn[k-1];
			assign side_prev = side_sn[k-1];
		end

		always_comb begin
			for (int l = 0; l < NL; l++) begin
				nxt[l] = div_step(acc_prev[l], dvsr_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (en) begin
				vld_sn[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvsr_sn[k] <= dvsr_in;
				acc_sn[k]  <= nxt;
				side_sn[k] <= side_prev;
			end
		end
	end

	assign out_valid = vld_sn[QP-1];
	assign acc_out   = acc_sn[QP-1];
	assign side_out  = side_sn[QP-1];

endmodule

// File: design/spi_back.sv
module spi_back
	import spi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [MRG_W-1:0] margin,
	input  acc_vec_t         acc,
	input  side_t            side,
	output logic             out_valid,
	output res_item_t        out_item
);

	logic [TF-1:0] ft, fu;
	logic          rnz_t, rnz_u, pass_t, pass_u, cross_ok;
	logic [TF:0]   lim;
	logic [QP:0]   magx, magy;
	logic [OW-1:0] fx, fy, px, py;

	logic      vld_q;
	res_item_t item_q;

	// margin checks on the parameters
	always_comb begin
		ft    = acc[LANE_T][QP-1 -: TF];
		fu    = acc[LANE_U][QP-1 -: TF];
		rnz_t = (acc[LANE_T][QP-TF-1:0] != '0) || (acc[LANE_T][AW-1:QP] != '0);
		rnz_u = (acc[LANE_U][QP-TF-1:0] != '0) || (acc[LANE_U][AW-1:QP] != '0);
		lim   = {1'b1, TF'(0)} - (TF+1)'(margin);
		pass_t = ((ft > TF'(margin)) || ((ft == TF'(margin)) && rnz_t))
			&& ((TF+1)'(ft) < lim);
		pass_u = ((fu > TF'(margin)) || ((fu == TF'(margin)) && rnz_u))
			&& ((TF+1)'(fu) < lim);
		cross_ok = side.ok && pass_t && pass_u;
	end

	// floored crossing point per axis
	always_comb begin
		magx = (QP+1)'(acc[LANE_X][QP-1:0])
			+ (QP+1)'(acc[LANE_X][AW-1:QP] != '0);
		magy = (QP+1)'(acc[LANE_Y][QP-1:0])
			+ (QP+1)'(acc[LANE_Y][AW-1:QP] != '0);
		fx = side.neg_x ? OW'(-magx) : OW'(acc[LANE_X][QP-1:0]);
		fy = side.neg_y ? OW'(-magy) : OW'(acc[LANE_Y][QP-1:0]);
		px = {side.base_x, PF'(0)} + fx;
		py = {side.base_y, PF'(0)} + fy;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q.crossing       <= cross_ok;
			item_q.frac_on_first  <= cross_ok ? {1'b0, ft} : '0;
			item_q.frac_on_second <= cross_ok ? {1'b0, fu} : '0;
			item_q.cross_x        <= cross_ok ? px : '0;
			item_q.cross_y        <= cross_ok ? py : '0;
		end
	end

	assign out_valid = vld_q;
	assign out_item  = item_q;

endmodule

// File: design/segment_pair_intersection.sv
// Segment pair intersection, exact integer arithmetic.
// Input channel seg_valid/seg_stall/seg_item carries two segments with
// signed 16-bit endpoints. Output channel res_valid/res_stall/res_item
// returns one item per input item: crossing flag, both parameters with
// 24 fraction bits and the crossing point with 16 fraction bits; all
// fields but the flag are zero when the segments do not cross strictly
// inside both, within the t_margin exclusion band.
// cfg_wr_en/cfg_wr_data write t_margin; write it only while idle.
// Items pass through registered stages of edge vectors, products and sign
// normalization, a restoring divider that produces one quotient bit
// per stage on four lanes, and the output register.
// Throughput is one item per cycle while the receiver does not stall.
// Reset clears all valid bits and sets t_margin to 17.
// When the receiver stalls a valid output item, the whole pipeline holds
// and seg_stall rises in the same cycle; nothing is lost or repeated.
module segment_pair_intersection
	import spi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             seg_valid,
	output logic             seg_stall,
	input  seg_item_t        seg_item,
	output logic             res_valid,
	input  logic             res_stall,
	output res_item_t        res_item,
	input  logic             cfg_wr_en,
	input  logic [MRG_W-1:0] cfg_wr_data
);

	logic             en;
	logic [MRG_W-1:0] margin_q;
	logic             f_vld, d_vld;
	logic [MW-1:0]    f_dvsr;
	acc_vec_t         f_acc, d_acc;
	side_t            f_side, d_side;

	// pipeline advances unless a result item is held
	assign en        = !(res_valid && res_stall);
	assign seg_stall = !en;

	// margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
		end else if (cfg_wr_en) begin
			margin_q <= cfg_wr_data;
		end
	end

	spi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (seg_valid),
		.in_item   (seg_item),
		.out_valid (f_vld),
		.dvsr      (f_dvsr),
		.acc       (f_acc),
		.side      (f_side)
	);

	spi_divpipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_vld),
		.dvsr      (f_dvsr),
		.acc_in    (f_acc),
		.side_in   (f_side),
		.out_valid (d_vld),
		.acc_out   (d_acc),
		.side_out  (d_side)
	);

	spi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_vld),
		.margin    (margin_q),
		.acc       (d_acc),
		.side      (d_side),
		.out_valid (res_valid),
		.out_item  (res_item)
	);

endmodule
